@@ hdl/thkr_pkg.sv @@
// Shared types, codes and defaults for the tap/hold key resolver.
`timescale 1ns / 1ps

package thkr_pkg;

    // Default number of tap/hold table entries
    localparam int TABLE_ENTRIES_DEF = 16;

    // Tapping term after reset, in ticks
    localparam logic [15:0] TAPPING_TERM_RST = 16'd200;

    // Input opcodes
    localparam logic [2:0] OP_PRESS   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_OTHER   = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_SET     = 3'd4;

    // Pending record mode
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_PENDING = 4'b0010,
        MODE_TAP     = 4'b0100,
        MODE_HOLD    = 4'b1000
    } t_mode;

    // One input beat
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  key_number;
        logic [7:0]  entry_number;
        logic        from_remote;
        logic [15:0] tap_code;
        logic [15:0] hold_code;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [15:0] keycode;
        logic        is_press;
        logic        remote_flag;
        logic [7:0]  source_key;
        logic        last;
    } t_out_beat;

endpackage

@@ hdl/tap_hold_key_resolver_unit.sv @@
// A result beat passes through the table read stage, then the result register; the second
// beat of a pair follows the first once the result register is free. Throughput: one
// input beat per cycle while the result side does not stall; a release of a pending key
// yields two result beats and holds the input until its second beat leaves the table read
// stage, set by the single result register that takes one beat per cycle when not stalled.
// Reset (synchronous, active low) clears the pending record, the table valid
// bits (unwritten entries read as zero), the pipeline, and sets the term to 200.
`timescale 1ns / 1ps

module tap_hold_key_resolver_unit #(
    parameter int TABLE_ENTRIES = thkr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  thkr_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output thkr_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    import thkr_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [8:0] EntLimit = 9'(TABLE_ENTRIES);

    // Configuration and pending record
    logic [15:0]             r_tapping_term;
    t_mode                   r_mode, n_mode;
    logic [7:0]              r_held_key, n_held_key;
    logic [IW-1:0]           r_held_entry, n_held_entry;
    logic                    r_held_remote, n_held_remote;
    logic [15:0]             r_elapsed, n_elapsed;
    logic [TABLE_ENTRIES-1:0] r_entry_ok;

    // Table read stage
    logic        r_s1_valid, r_s1_two, r_s1_second, r_s1_hold, r_s1_p0, r_s1_ok;
    logic [7:0]  r_s1_key;
    logic        r_s1_remote;

    // Result register
    logic      r_out_valid;
    t_out_beat r_out_data;

    logic        accept, out_free, s1_emit, s1_done;
    logic        ent_ok, tbl_we;
    logic        ev, ev_two, ev_hold, ev_p0;
    logic [15:0] tick_inc;
    logic [31:0] ram_rdata, codes;
    logic [IW-1:0] ent_idx;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_emit    = r_s1_valid && out_free;
    assign s1_done    = s1_emit && (!r_s1_two || r_s1_second);
    assign o_in_ready = !r_s1_valid || s1_done;
    assign accept     = i_in_valid && o_in_ready;

    assign ent_ok   = ({1'b0, i_in_data.entry_number} < EntLimit);
    assign ent_idx  = i_in_data.entry_number[IW-1:0];
    assign tick_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    // Decode the beat against the pending record
    always_comb begin
        n_mode        = r_mode;
        n_held_key    = r_held_key;
        n_held_entry  = r_held_entry;
        n_held_remote = r_held_remote;
        n_elapsed     = r_elapsed;
        ev            = 1'b0;
        ev_two        = 1'b0;
        ev_hold       = 1'b0;
        ev_p0         = 1'b1;
        tbl_we        = 1'b0;
        case (i_in_data.opcode)
            OP_PRESS: begin
                if (ent_ok) begin
                    if (r_mode == MODE_PENDING) begin
                        ev      = 1'b1;
                        ev_hold = 1'b1;
                    end
                    n_mode        = MODE_PENDING;
                    n_held_key    = i_in_data.key_number;
                    n_held_entry  = ent_idx;
                    n_held_remote = i_in_data.from_remote;
                    n_elapsed     = 16'd0;
                end
            end
            OP_RELEASE: begin
                if (r_mode != MODE_IDLE && i_in_data.key_number == r_held_key) begin
                    n_mode = MODE_IDLE;
                    ev     = 1'b1;
                    unique case (r_mode)
                        MODE_PENDING: begin
                            ev_two = 1'b1;
                        end
                        MODE_HOLD: begin
                            ev_hold = 1'b1;
                            ev_p0   = 1'b0;
                        end
                        MODE_TAP: begin
                            ev_p0 = 1'b0;
                        end
                        default: begin
                            ev = 1'b0;
                        end
                    endcase
                end
            end
            OP_OTHER: begin
                if (r_mode == MODE_PENDING) begin
                    ev      = 1'b1;
                    ev_hold = 1'b1;
                    n_mode  = MODE_HOLD;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_PENDING) begin
                    n_elapsed = tick_inc;
                    if (tick_inc >= r_tapping_term) begin
                        ev      = 1'b1;
                        ev_hold = 1'b1;
                        n_mode  = MODE_HOLD;
                    end
                end
            end
            OP_SET: begin
                tbl_we = ent_ok;
            end
            default: begin
            end
        endcase
    end

    // Tap/hold code table: {hold, tap} per entry
    thkr_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && tbl_we),
        .i_waddr (ent_idx),
        .i_wdata ({i_in_data.hold_code, i_in_data.tap_code}),
        .i_re    (accept),
        .i_raddr (r_held_entry),
        .o_rdata (ram_rdata)
    );

    // Hold configuration, record and table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tapping_term <= TAPPING_TERM_RST;
            r_mode         <= MODE_IDLE;
            r_held_key     <= '0;
            r_held_entry   <= '0;
            r_held_remote  <= 1'b0;
            r_elapsed      <= '0;
            r_entry_ok     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tapping_term <= i_cfg_wdata;
            end
            if (accept) begin
                r_mode        <= n_mode;
                r_held_key    <= n_held_key;
                r_held_entry  <= n_held_entry;
                r_held_remote <= n_held_remote;
                r_elapsed     <= n_elapsed;
                if (tbl_we) begin
                    r_entry_ok[ent_idx] <= 1'b1;
                end
            end
        end
    end

    // Advance the table read stage, one result beat per cycle while the result register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_second <= 1'b0;
        end else if (accept) begin
            r_s1_valid  <= ev;
            r_s1_second <= 1'b0;
        end else if (s1_emit) begin
            if (s1_done) begin
                r_s1_valid <= 1'b0;
            end else begin
                r_s1_second <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_two    <= ev_two;
            r_s1_hold   <= ev_hold;
            r_s1_p0     <= ev_p0;
            r_s1_key    <= r_held_key;
            r_s1_remote <= r_held_remote;
            r_s1_ok     <= r_entry_ok[r_held_entry];
        end
    end

    // Unwritten entries read as zero
    assign codes = r_s1_ok ? ram_rdata : 32'd0;

    // Result register: load from the read stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_data.keycode     <= r_s1_hold ? codes[31:16] : codes[15:0];
            r_out_data.is_press    <= r_s1_second ? 1'b0 : r_s1_p0;
            r_out_data.remote_flag <= r_s1_remote;
            r_out_data.source_key  <= r_s1_key;
            r_out_data.last        <= !r_s1_two || r_s1_second;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/thkr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module thkr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/thkr_checker.sv @@
// Port-level checker for the tap/hold key resolver and its bind.
`timescale 1ns / 1ps

module thkr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input thkr_pkg::t_out_beat o_out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Reset empties the result side and opens the input
    a_rst_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // Only a tap press opens a two-beat pair
    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.is_press)
        else $error("non-final beat is not a press");

    // The tap release follows its press at once, same code and key
    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=>
            o_out_valid && !o_out_data.is_press && o_out_data.last &&
            o_out_data.keycode == $past(o_out_data.keycode) &&
            o_out_data.source_key == $past(o_out_data.source_key))
        else $error("tap release did not follow tap press");

endmodule

bind tap_hold_key_resolver_unit thkr_checker u_thkr_checker (.*);

@@ tb/tap_hold_key_resolver_unit_test.sv @@
// Self-checking testbench for the tap/hold key resolver: directed table, random key sequences.
`timescale 1ns / 1ps

module tap_hold_key_resolver_unit_test;

    import thkr_pkg::*;

    localparam int N_ENTRIES   = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_GAP  = 8;

    // One line of the directed table; n_exp < 0 leaves the result to the predictor
    typedef struct {
        t_in_beat  beat;
        int        n_exp;
        t_out_beat exp0;
        t_out_beat exp1;
    } t_key_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_beat    in_data;
    logic        out_valid;
    logic        out_ready = 1'b1;
    t_out_beat   out_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // Mirror of the pending record, the code table and the term
    t_mode       rec_mode    = MODE_IDLE;
    logic [7:0]  rec_key     = '0;
    logic [7:0]  rec_entry   = '0;
    logic        rec_remote  = 1'b0;
    logic [15:0] rec_ticks   = '0;
    logic [15:0] term_model  = TAPPING_TERM_RST;
    logic [15:0] tap_tbl [N_ENTRIES];
    logic [15:0] hold_tbl[N_ENTRIES];

    t_out_beat   fresh_events[$];
    t_out_beat   pending_events[$];
    t_key_row    key_rows[$];

    bit          in_idle_on  = 1'b0;
    bit          stall_on    = 1'b0;
    int          stall_left  = 0;
    int          mismatches  = 0;
    int          beats_sent  = 0;
    int          beats_live  = 0;
    int          events_seen = 0;
    int          term_writes = 0;
    int          cycle_count = 0;
    t_out_beat   want;

    tap_hold_key_resolver_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Build one key event
    function automatic t_out_beat ev(input logic [15:0] code, input logic press,
                                     input logic remote, input logic [7:0] key,
                                     input logic last_flag);
        t_out_beat e;
        e.keycode     = code;
        e.is_press    = press;
        e.remote_flag = remote;
        e.source_key  = key;
        e.last        = last_flag;
        return e;
    endfunction

    function automatic t_in_beat make_beat(input logic [2:0] op, input logic [7:0] key,
                                           input logic [7:0] ent, input logic remote,
                                           input logic [15:0] tc, input logic [15:0] hc);
        t_in_beat b;
        b.opcode       = op;
        b.key_number   = key;
        b.entry_number = ent;
        b.from_remote  = remote;
        b.tap_code     = tc;
        b.hold_code    = hc;
        return b;
    endfunction

    function automatic t_key_row row(input logic [2:0] op, input logic [7:0] key,
                                     input logic [7:0] ent, input logic remote,
                                     input logic [15:0] tc, input logic [15:0] hc,
                                     input int n_exp = -1,
                                     input t_out_beat e0 = '0,
                                     input t_out_beat e1 = '0);
        t_key_row r;
        r.beat  = make_beat(op, key, ent, remote, tc, hc);
        r.n_exp = n_exp;
        r.exp0  = e0;
        r.exp1  = e1;
        return r;
    endfunction

    // Turn the pending key into a hold and emit the hold press
    function automatic void resolve_as_hold();
        fresh_events.push_back(ev(hold_tbl[rec_entry], 1'b1, rec_remote, rec_key, 1'b0));
        rec_mode = MODE_HOLD;
    endfunction

    // Advance the record by one input beat; returns 1 if the beat was not ignored
    function automatic bit resolve_beat(input t_in_beat b);
        t_out_beat tail;
        bit        live;
        live = 1'b0;
        fresh_events.delete();
        case (b.opcode)
            OP_PRESS: begin
                if (b.entry_number < N_ENTRIES) begin
                    live = 1'b1;
                    if (rec_mode == MODE_PENDING) resolve_as_hold();
                    rec_mode   = MODE_PENDING;
                    rec_key    = b.key_number;
                    rec_entry  = b.entry_number;
                    rec_remote = b.from_remote;
                    rec_ticks  = '0;
                end
            end
            OP_RELEASE: begin
                if (rec_mode != MODE_IDLE && rec_key == b.key_number) begin
                    live = 1'b1;
                    if (rec_mode == MODE_PENDING) begin
                        fresh_events.push_back(ev(tap_tbl[rec_entry], 1'b1, rec_remote,
                                                  rec_key, 1'b0));
                        fresh_events.push_back(ev(tap_tbl[rec_entry], 1'b0, rec_remote,
                                                  rec_key, 1'b0));
                    end else if (rec_mode == MODE_HOLD) begin
                        fresh_events.push_back(ev(hold_tbl[rec_entry], 1'b0, rec_remote,
                                                  rec_key, 1'b0));
                    end else begin
                        fresh_events.push_back(ev(tap_tbl[rec_entry], 1'b0, rec_remote,
                                                  rec_key, 1'b0));
                    end
                    rec_mode = MODE_IDLE;
                end
            end
            OP_OTHER: begin
                if (rec_mode == MODE_PENDING) begin
                    live = 1'b1;
                    resolve_as_hold();
                end
            end
            OP_TICK: begin
                if (rec_mode == MODE_PENDING) begin
                    live = 1'b1;
                    // saturate, then compare against the term
                    if (rec_ticks != 16'hFFFF) rec_ticks = rec_ticks + 16'd1;
                    if (rec_ticks >= term_model) resolve_as_hold();
                end
            end
            OP_SET: begin
                if (b.entry_number < N_ENTRIES) begin
                    live = 1'b1;
                    tap_tbl[b.entry_number]  = b.tap_code;
                    hold_tbl[b.entry_number] = b.hold_code;
                end
            end
            default: ;
        endcase
        // flag the final event of this beat
        if (fresh_events.size() > 0) begin
            tail = fresh_events.pop_back();
            tail.last = 1'b1;
            fresh_events.push_back(tail);
        end
        return live;
    endfunction

    // Present one beat, wait for it to be taken, then queue what it should produce
    task automatic drive_beat(input t_in_beat b, input int n_exp = -1,
                              input t_out_beat e0 = '0, input t_out_beat e1 = '0);
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        if (resolve_beat(b)) beats_live++;
        beats_sent++;
        if (n_exp < 0) begin
            foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
        end else begin
            if (n_exp > 0) pending_events.push_back(e0);
            if (n_exp > 1) pending_events.push_back(e1);
        end
    endtask

    // Drop valid and wait until every expected event has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic set_term(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        term_model  = v;
        term_writes++;
    endtask

    // Mostly press / tick / release sequences, with some table writes and noise
    task automatic run_random_phase(input int target);
        int         start;
        int         span;
        int         pick;
        logic [7:0] key;
        logic [7:0] ent;
        start = beats_sent;
        while (beats_sent - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                ent = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                                  : 8'($urandom_range(0, N_ENTRIES - 1));
                drive_beat(make_beat(OP_SET, 8'($urandom), ent, 1'($urandom),
                                     16'($urandom), 16'($urandom)));
            end else if (pick < 80) begin
                key = 8'($urandom);
                ent = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(16, 255))
                                                   : 8'($urandom_range(0, N_ENTRIES - 1));
                drive_beat(make_beat(OP_PRESS, key, ent, 1'($urandom), 16'($urandom),
                                     16'($urandom)));
                span = (term_model < 20) ? term_model + 3 : 30;
                repeat ($urandom_range(0, span)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5, 6:
                            drive_beat(make_beat(OP_TICK, 8'($urandom), 8'($urandom),
                                                 1'($urandom), 16'($urandom),
                                                 16'($urandom)));
                        7:
                            drive_beat(make_beat(OP_OTHER, 8'($urandom), 8'($urandom),
                                                 1'($urandom), 16'($urandom),
                                                 16'($urandom)));
                        8:
                            drive_beat(make_beat(OP_RELEASE, key ^ 8'($urandom_range(1, 255)),
                                                 8'($urandom), 1'($urandom), 16'($urandom),
                                                 16'($urandom)));
                        default:
                            drive_beat(make_beat(3'($urandom_range(5, 7)), 8'($urandom),
                                                 8'($urandom), 1'($urandom),
                                                 16'($urandom), 16'($urandom)));
                    endcase
                end
                // leave some keys held so the next press replaces them
                if ($urandom_range(0, 5) != 0)
                    drive_beat(make_beat(OP_RELEASE, key, 8'($urandom), 1'($urandom),
                                         16'($urandom), 16'($urandom)));
            end else begin
                drive_beat(make_beat(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                                     1'($urandom), 16'($urandom), 16'($urandom)));
            end
        end
    endtask

    function automatic void note_mismatch(input string what, input t_out_beat exp_b,
                                          input t_out_beat got_b);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected code %h press %b remote %b key %h last %b,",
                     what, exp_b.keycode, exp_b.is_press, exp_b.remote_flag,
                     exp_b.source_key, exp_b.last,
                     " got code %h press %b remote %b key %h last %b",
                     got_b.keycode, got_b.is_press, got_b.remote_flag,
                     got_b.source_key, got_b.last);
    endfunction

    // Random stall bursts on the result side
    always @(posedge clk) begin
        if (!rst_n || !stall_on) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 15);
            out_ready  <= 1'b0;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                note_mismatch("nothing expected", '0, out_data);
            end else begin
                want = pending_events.pop_front();
                if (out_data.keycode !== want.keycode || out_data.is_press !== want.is_press
                        || out_data.remote_flag !== want.remote_flag
                        || out_data.source_key !== want.source_key
                        || out_data.last !== want.last)
                    note_mismatch("field", want, out_data);
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tap_hold_key_resolver_unit_test NOT OK");
            $finish;
        end
    end

    initial begin
        int         phase_terms[7];
        logic [7:0] long_key;
        logic [7:0] long_ent;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        foreach (tap_tbl[i]) begin
            tap_tbl[i]  = '0;
            hold_tbl[i] = '0;
        end

        // Directed table, run with the reset term and a cleared code table
        key_rows.push_back(row(OP_RELEASE, 8'd5, 8'd0, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_PRESS, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_RELEASE, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0, 2,
                               ev(16'h0000, 1'b1, 1'b0, 8'h00, 1'b0),
                               ev(16'h0000, 1'b0, 1'b0, 8'h00, 1'b1)));
        key_rows.push_back(row(OP_SET, 8'd0, 8'd15, 1'b0, 16'hFFFF, 16'hFFFF, 0));
        key_rows.push_back(row(OP_SET, 8'd0, 8'd16, 1'b0, 16'h1234, 16'h5678, 0));
        key_rows.push_back(row(OP_SET, 8'hFF, 8'hFF, 1'b1, 16'hAAAA, 16'h5555, 0));
        key_rows.push_back(row(OP_SET, 8'd0, 8'd0, 1'b0, 16'h0004, 16'h00E0));
        key_rows.push_back(row(OP_PRESS, 8'hFF, 8'd15, 1'b1, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_OTHER, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0, 1,
                               ev(16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1)));
        key_rows.push_back(row(OP_OTHER, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_RELEASE, 8'd7, 8'd0, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_RELEASE, 8'hFF, 8'd0, 1'b0, 16'h0, 16'h0, 1,
                               ev(16'hFFFF, 1'b0, 1'b1, 8'hFF, 1'b1)));
        key_rows.push_back(row(OP_PRESS, 8'd3, 8'hFF, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(OP_PRESS, 8'd3, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_PRESS, 8'd4, 8'd15, 1'b1, 16'h0, 16'h0));
        key_rows.push_back(row(OP_RELEASE, 8'd4, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(3'd5, 8'h00, 8'h00, 1'b0, 16'h0, 16'h0, 0));
        key_rows.push_back(row(3'd7, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 0));
        key_rows.push_back(row(OP_PRESS, 8'd9, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_TICK, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_RELEASE, 8'd9, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_PRESS, 8'd1, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_OTHER, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_PRESS, 8'd2, 8'd15, 1'b1, 16'h0, 16'h0));
        key_rows.push_back(row(OP_RELEASE, 8'd1, 8'd0, 1'b0, 16'h0, 16'h0));
        key_rows.push_back(row(OP_RELEASE, 8'd2, 8'd0, 1'b0, 16'h0, 16'h0));

        // Hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_on = 1'b1;
        stall_on   = 1'b1;
        foreach (key_rows[i])
            drive_beat(key_rows[i].beat, key_rows[i].n_exp, key_rows[i].exp0,
                       key_rows[i].exp1);
        settle();

        // Random sequences under several terms, extremes included
        phase_terms = '{1, 0, 4, 0, 9, 65535, 2};
        phase_terms[3] = $urandom_range(2, 12);
        foreach (phase_terms[p]) begin
            in_idle_on = (p != 3);
            stall_on   = (p != 3);
            set_term(16'(phase_terms[p]));
            run_random_phase(160);
            settle();
        end

        // Closing press held exactly to its term, with no idling
        in_idle_on = 1'b0;
        stall_on   = 1'b0;
        set_term(16'd40);
        long_key = 8'($urandom);
        long_ent = 8'($urandom_range(0, N_ENTRIES - 1));
        drive_beat(make_beat(OP_PRESS, long_key, long_ent, 1'($urandom), 16'($urandom),
                             16'($urandom)));
        repeat (40)
            drive_beat(make_beat(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                                 16'($urandom), 16'($urandom)));
        drive_beat(make_beat(OP_RELEASE, long_key, 8'($urandom), 1'($urandom),
                             16'($urandom), 16'($urandom)));
        settle();

        if (pending_events.size() != 0) begin
            mismatches += pending_events.size();
            $display("%0d expected events never arrived", pending_events.size());
        end

        $display("sent %0d input beats (%0d acted on), checked %0d key events",
                 beats_sent, beats_live, events_seen);
        $display("tapping term written %0d times, 0 to 65535, closing key held to its term",
                 term_writes);
        if (mismatches == 0) begin
            $display("tap_hold_key_resolver_unit_test OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tap_hold_key_resolver_unit_test NOT OK");
        end
        $finish;
    end

endmodule
